>>> rtl/c2dzp_pkg.sv
// Shared types and constants for the zero-padded 2D convolution unit.
// No dependencies.
`timescale 1ns / 1ps

package c2dzp_pkg;

    localparam int MAX_IMAGE  = 128;
    localparam int MAX_KERNEL = 7;
    localparam int MAX_PAD    = 4;

    localparam int PAD_SIDE   = MAX_IMAGE + 2 * MAX_PAD;
    localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int LB_SLOTS   = MAX_KERNEL - 1;
    localparam int LB_W       = LB_SLOTS * 16;
    localparam int LB_AW      = $clog2(PAD_SIDE);
    localparam int RES_DEPTH  = 8;
    localparam int RES_AW     = $clog2(RES_DEPTH);

    // item opcodes
    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // register indexes
    localparam logic [1:0] REG_IMAGE_SIZE  = 2'd0;
    localparam logic [1:0] REG_KERNEL_SIZE = 2'd1;
    localparam logic [1:0] REG_PAD_WIDTH   = 2'd2;

    typedef struct packed {
        logic               op;
        logic [5:0]         coef_index;
        logic signed [15:0] coef_value;
        logic signed [15:0] pixel;
    } item_t;

    typedef struct packed {
        logic signed [39:0] conv_sum;
        logic [7:0]         out_row;
        logic [7:0]         out_col;
        logic               frame_last;
    } result_t;

    // per-item position info carried down the pipeline
    typedef struct packed {
        logic       emit;
        logic [7:0] row;
        logic [7:0] col;
        logic       last;
    } pos_t;

endpackage

>>> rtl/conv2d_zero_padded_unit.sv
// Zero-padded 2D convolution unit: column line buffer, window, 49 MAC lanes,
// result queue. Depends on c2dzp_pkg.
`timescale 1ns / 1ps

//  channel | dir | handshake             | payload
//  item    | in  | item_valid/item_stall | item   (c2dzp_pkg::item_t)
//  result  | out | result_valid/result_stall | result (c2dzp_pkg::result_t)
//  config  | in  | APB psel/penable      | paddr, pwdata, prdata
//
// One request per clock is accepted while item_stall is low; the line buffer's
// separate read and write ports with last-write forwarding allow this. A result
// is registered through buffer read, multiply, row sums and total before it
// enters the queue. item_stall rises once the queue plus the results in flight
// reach 8 entries. Reset clears control state only; idle lanes are masked, so
// the line buffer needs no clearing pass.

module conv2d_zero_padded_unit
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  c2dzp_pkg::item_t        item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output c2dzp_pkg::result_t      result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import c2dzp_pkg::*;

    // configuration registers
    logic [7:0] image_size_reg;
    logic [2:0] kernel_size_reg;
    logic [2:0] pad_width_reg;
    logic       cfg_wr;
    logic       cfg_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = (paddr[3:2] == REG_IMAGE_SIZE) || (paddr[3:2] == REG_KERNEL_SIZE)
                  || (paddr[3:2] == REG_PAD_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg  <= 8'd8;
            kernel_size_reg <= 3'd3;
            pad_width_reg   <= 3'd0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_IMAGE_SIZE:  image_size_reg  <= pwdata[7:0];
                REG_KERNEL_SIZE: kernel_size_reg <= pwdata[2:0];
                REG_PAD_WIDTH:   pad_width_reg   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IMAGE_SIZE:  prdata = {24'd0, image_size_reg};
            REG_KERNEL_SIZE: prdata = {29'd0, kernel_size_reg};
            REG_PAD_WIDTH:   prdata = {29'd0, pad_width_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // effective sizes
    logic [7:0] img_eff;
    logic [2:0] ks_eff;
    logic [2:0] pad_eff;
    logic [7:0] side;

    always_comb
    begin
        img_eff = image_size_reg;
        if (image_size_reg == 8'd0)
            img_eff = 8'd1;
        else if (image_size_reg > 8'(MAX_IMAGE))
            img_eff = 8'(MAX_IMAGE);
        ks_eff  = (kernel_size_reg == 3'd0) ? 3'd1 : kernel_size_reg;
        pad_eff = (pad_width_reg > 3'(MAX_PAD)) ? 3'(MAX_PAD) : pad_width_reg;
        side    = img_eff + {4'd0, pad_eff, 1'b0};
    end

    // accept and raster position
    logic       accept;
    logic       acc_pix;
    logic [7:0] raster_row_reg, raster_col_reg;
    logic [7:0] raster_row_next, raster_col_next;
    logic [7:0] r0, c0;
    logic       border0;
    pos_t       pos0;

    assign accept  = item_valid && !item_stall;
    assign acc_pix = accept && (item.op == OP_PIXEL);

    always_comb
    begin
        r0 = raster_row_reg;
        c0 = raster_col_reg;
        if (r0 >= side || c0 >= side)
        begin
            r0 = 8'd0;
            c0 = 8'd0;
        end
        border0 = (r0 < {5'd0, pad_eff}) || (r0 >= side - {5'd0, pad_eff})
               || (c0 < {5'd0, pad_eff}) || (c0 >= side - {5'd0, pad_eff});
        pos0.emit = ({5'd0, ks_eff} <= side) && ({1'b0, r0} + 9'd1 >= {6'd0, ks_eff})
                 && ({1'b0, c0} + 9'd1 >= {6'd0, ks_eff});
        pos0.row  = r0 + 8'd1 - {5'd0, ks_eff};
        pos0.col  = c0 + 8'd1 - {5'd0, ks_eff};
        pos0.last = (r0 == side - 8'd1) && (c0 == side - 8'd1);
        raster_row_next = r0;
        raster_col_next = c0 + 8'd1;
        if (raster_col_next >= side)
        begin
            raster_col_next = 8'd0;
            raster_row_next = (r0 + 8'd1 >= side) ? 8'd0 : r0 + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_row_reg <= 8'd0;
            raster_col_reg <= 8'd0;
        end
        else if (cfg_wr && cfg_hit)
        begin
            raster_row_reg <= 8'd0;
            raster_col_reg <= 8'd0;
        end
        else if (acc_pix)
        begin
            raster_row_reg <= raster_row_next;
            raster_col_reg <= raster_col_next;
        end
    end

    // stage 1: line buffer read returns, column formed and written back
    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic               s1_fwd_reg;
    logic [LB_AW-1:0]   s1_addr_reg;
    logic signed [15:0] s1_pix_reg;
    logic [5:0]         s1_cidx_reg;
    logic signed [15:0] s1_cval_reg;
    pos_t               s1_pos_reg;
    logic [LB_AW-1:0]   rd_addr;

    logic [LB_W-1:0]    lb_mem [PAD_SIDE];
    logic [LB_W-1:0]    lb_rd_reg;
    logic [LB_W-1:0]    lb_last_wr_reg;
    logic [LB_W-1:0]    lb_prev;
    logic [LB_W-1:0]    lb_wdata;
    logic               s1_pix_valid;

    assign rd_addr      = c0[LB_AW-1:0];
    assign s1_pix_valid = s1_valid_reg && (s1_op_reg == OP_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= item.op;
            s1_fwd_reg  <= s1_pix_valid && (s1_addr_reg == rd_addr);
            s1_addr_reg <= rd_addr;
            s1_pix_reg  <= border0 ? 16'sd0 : item.pixel;
            s1_cidx_reg <= item.coef_index;
            s1_cval_reg <= item.coef_value;
            s1_pos_reg  <= pos0;
        end
    end

    // line buffer memory: each word holds one column of the older rows
    always_ff @(posedge clk)
    begin
        if (acc_pix)
            lb_rd_reg <= lb_mem[rd_addr];
        if (s1_pix_valid)
        begin
            lb_mem[s1_addr_reg] <= lb_wdata;
            lb_last_wr_reg      <= lb_wdata;
        end
    end

    // back-to-back access of one column is served from the last write
    assign lb_prev  = s1_fwd_reg ? lb_last_wr_reg : lb_rd_reg;
    assign lb_wdata = {lb_prev[LB_W-17:0], s1_pix_reg};

    // window: win_reg[k][m] is row r-k, column c-m
    logic signed [15:0] win_reg [MAX_KERNEL][MAX_KERNEL];

    always_ff @(posedge clk)
    begin
        if (s1_pix_valid)
        begin
            for (int k = 0; k < MAX_KERNEL; k++)
            begin
                for (int m = MAX_KERNEL - 1; m > 0; m--)
                    win_reg[k][m] <= win_reg[k][m-1];
            end
            win_reg[0][0] <= s1_pix_reg;
            for (int k = 1; k < MAX_KERNEL; k++)
                win_reg[k][0] <= lb_prev[16*k-1 -: 16];
        end
    end

    // stage 2: coefficient select and multiply
    logic               s2_valid_reg;
    logic               s2_op_reg;
    logic [5:0]         s2_cidx_reg;
    logic signed [15:0] s2_cval_reg;
    pos_t               s2_pos_reg;
    logic signed [15:0] coef_reg [COEF_DEPTH];
    logic signed [15:0] lane_coef [MAX_KERNEL][MAX_KERNEL];
    logic signed [15:0] lane_win [MAX_KERNEL][MAX_KERNEL];
    logic signed [31:0] prod_reg [MAX_KERNEL][MAX_KERNEL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg   <= s1_op_reg;
        s2_cidx_reg <= s1_cidx_reg;
        s2_cval_reg <= s1_cval_reg;
        s2_pos_reg  <= s1_pos_reg;
    end

    // coefficient writes take effect in order with the pixels
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && (s2_op_reg == OP_COEF) && (s2_cidx_reg < 6'(COEF_DEPTH)))
            coef_reg[s2_cidx_reg] <= s2_cval_reg;
    end

    // lane (a,b) holds coefficient (ks-1-a)*ks + (ks-1-b); idle lanes get zero
    // coefficient and zero data, so stale buffer words never reach the sum
    always_comb
    begin
        for (int a = 0; a < MAX_KERNEL; a++)
        begin
            for (int b = 0; b < MAX_KERNEL; b++)
            begin
                lane_coef[a][b] = 16'sd0;
                lane_win[a][b]  = 16'sd0;
                for (int s = 1; s <= MAX_KERNEL; s++)
                begin
                    if (ks_eff == 3'(s) && a < s && b < s)
                    begin
                        lane_coef[a][b] = coef_reg[(s-1-a)*s + (s-1-b)];
                        lane_win[a][b]  = win_reg[a][b];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < MAX_KERNEL; a++)
        begin
            for (int b = 0; b < MAX_KERNEL; b++)
                prod_reg[a][b] <= lane_win[a][b] * lane_coef[a][b];
        end
    end

    // stage 3: row sums; stage 4: total
    logic               s3_valid_reg, s4_valid_reg;
    pos_t               s3_pos_reg, s4_pos_reg;
    logic signed [34:0] row_sum_reg [MAX_KERNEL];
    logic signed [34:0] row_sum [MAX_KERNEL];
    logic signed [39:0] total_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg && (s2_op_reg == OP_PIXEL);
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_comb
    begin
        for (int a = 0; a < MAX_KERNEL; a++)
        begin
            row_sum[a] = 35'sd0;
            for (int b = 0; b < MAX_KERNEL; b++)
                row_sum[a] = row_sum[a] + 35'(prod_reg[a][b]);
        end
        total_sum = 40'sd0;
        for (int a = 0; a < MAX_KERNEL; a++)
            total_sum = total_sum + 40'(row_sum_reg[a]);
    end

    always_ff @(posedge clk)
    begin
        s3_pos_reg  <= s2_pos_reg;
        s4_pos_reg  <= s3_pos_reg;
        row_sum_reg <= row_sum;
    end

    // result queue
    result_t            res_mem [RES_DEPTH];
    logic [RES_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [RES_AW:0]    res_cnt_reg;
    logic               push, pop;
    logic [2:0]         in_flight;
    logic [RES_AW+1:0]  committed;

    assign push = s4_valid_reg && s4_pos_reg.emit;
    assign pop  = result_valid && !result_stall;
    assign in_flight = 3'($countones({s1_pix_valid && s1_pos_reg.emit,
                                      s2_valid_reg && (s2_op_reg == OP_PIXEL)
                                          && s2_pos_reg.emit,
                                      s3_valid_reg && s3_pos_reg.emit,
                                      push}));
    assign committed  = {1'b0, res_cnt_reg} + {{(RES_AW-1){1'b0}}, in_flight};
    assign item_stall = committed >= (RES_AW+2)'(RES_DEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
            res_mem[wr_ptr_reg] <= '{conv_sum: total_sum, out_row: s4_pos_reg.row,
                                     out_col: s4_pos_reg.col,
                                     frame_last: s4_pos_reg.last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            res_cnt_reg <= res_cnt_reg + {{RES_AW{1'b0}}, push} - {{RES_AW{1'b0}}, pop};
        end
    end

    assign result_valid = (res_cnt_reg != '0);
    assign result       = res_mem[rd_ptr_reg];

`ifndef SYNTHESIS
    // queue plus in-flight results never exceed the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        committed <= (RES_AW+2)'(RES_DEPTH))
        else $error("result queue overcommitted");

    // a push never finds the queue full
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (res_cnt_reg < (RES_AW+1)'(RES_DEPTH) || pop))
        else $error("push into full result queue");

    // forwarding only happens when a column is hit twice in a row
    a_fwd_side: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_pix_valid && s1_fwd_reg) |-> (side == 8'd1))
        else $error("unexpected line buffer forward");

    // the last result of a frame sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        (push && s4_pos_reg.last) |-> (s4_pos_reg.row == s4_pos_reg.col))
        else $error("frame_last off diagonal");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking bench for conv2d_zero_padded_unit: coefficients, one frame, directed
// table, random frames. Uses c2dzp_pkg and unit RTL; carries own window-sum predictor.
`timescale 1ns / 1ps

module tb_top;
    import c2dzp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    conv2d_zero_padded_unit u_dut (.*);

    always #5 clk = ~clk;

    // predictor copy of the block state
    int          coef_mem [COEF_DEPTH];
    int          row_mem [MAX_KERNEL][PAD_SIDE];
    int unsigned pos_row, pos_col;
    int unsigned cfg_img = 8, cfg_ks = 3, cfg_pad = 0;

    result_t sum_q [$];
    int      err_cnt = 0;
    int      send_idle_pct = 35;
    int      recv_stall_pct = 82;

    // one entry of the directed table
    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } dir_row_t;

    // window sum for one request; returns 1 when a result is due
    function automatic bit conv_predict(input item_t it, output result_t res);
        int unsigned ks, pad, side, r, c, i, j;
        longint      acc;
        bit          border, emit;
        ks   = (cfg_ks < 1) ? 1 : (cfg_ks > MAX_KERNEL ? MAX_KERNEL : cfg_ks);
        pad  = (cfg_pad > MAX_PAD) ? MAX_PAD : cfg_pad;
        side = ((cfg_img < 1) ? 1 : (cfg_img > MAX_IMAGE ? MAX_IMAGE : cfg_img)) + 2 * pad;
        res  = '0;
        acc  = 0;
        if (it.op == OP_COEF)
        begin
            if (it.coef_index < COEF_DEPTH)
                coef_mem[it.coef_index] = int'(it.coef_value);
            return 1'b0;
        end
        r = pos_row;
        c = pos_col;
        if (r >= side || c >= side)
        begin
            r = 0;
            c = 0;
        end
        border = r < pad || r >= side - pad || c < pad || c >= side - pad;
        row_mem[r % MAX_KERNEL][c] = border ? 0 : int'(it.pixel);
        emit = ks <= side && r + 1 >= ks && c + 1 >= ks;
        if (emit)
        begin
            i = r + 1 - ks;
            j = c + 1 - ks;
            for (int k = 0; k < ks; k++)
                for (int l = 0; l < ks; l++)
                    acc += longint'(row_mem[(i + k) % MAX_KERNEL][j + l])
                         * longint'(coef_mem[k * ks + l]);
            res.conv_sum   = acc[39:0];
            res.out_row    = i[7:0];
            res.out_col    = j[7:0];
            res.frame_last = (r == side - 1 && c == side - 1);
        end
        c++;
        if (c >= side)
        begin
            c = 0;
            r++;
            if (r >= side)
                r = 0;
        end
        pos_row = r;
        pos_col = c;
        return emit;
    endfunction

    // APB write: setup then access; also restarts the predicted raster
    task automatic reg_write(input logic [1:0] idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_SIZE:  cfg_img = val & 8'hFF;
            REG_KERNEL_SIZE: cfg_ks  = val & 3'h7;
            default:         cfg_pad = val & 3'h7;
        endcase
        pos_row = 0;
        pos_col = 0;
    endtask

    // send one request; a typed result replaces the predicted one
    task automatic send_req(input item_t it, input bit typed, input result_t typed_res);
        result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        if (conv_predict(it, res))
            sum_q = {sum_q, (typed ? typed_res : res)};
    endtask

    // let every expected result arrive, then the pipeline settle
    task automatic drain();
        item_valid <= 1'b0;
        wait (sum_q.size() == 0);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly pixels over the configured frame, a few coefficient rewrites
    task automatic run_frames(input int unsigned img, ks, pad, n_items);
        item_t it;
        reg_write(REG_IMAGE_SIZE, img);
        reg_write(REG_KERNEL_SIZE, ks);
        reg_write(REG_PAD_WIDTH, pad);
        for (int n = 0; n < n_items; n++)
        begin
            it            = '0;
            it.op         = ($urandom_range(19) == 0) ? OP_COEF : OP_PIXEL;
            it.coef_index = $urandom_range(99) < 90 ? 6'($urandom_range(COEF_DEPTH - 1))
                                                    : 6'($urandom_range(63, COEF_DEPTH));
            it.coef_value = rand_sample();
            it.pixel      = rand_sample();
            send_req(it, 1'b0, '0);
        end
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t exp_res;
        if (result_valid && !result_stall)
        begin
            if (sum_q.size() == 0)
            begin
                $error("unexpected result: sum %h row %0d col %0d", result.conv_sum,
                       result.out_row, result.out_col);
                err_cnt++;
            end
            else
            begin
                exp_res = sum_q.pop_front();
                if (result.conv_sum !== exp_res.conv_sum)
                begin
                    $error("conv_sum exp %h got %h", exp_res.conv_sum, result.conv_sum);
                    err_cnt++;
                end
                if (result.out_row !== exp_res.out_row)
                begin
                    $error("out_row exp %0d got %0d", exp_res.out_row, result.out_row);
                    err_cnt++;
                end
                if (result.out_col !== exp_res.out_col)
                begin
                    $error("out_col exp %0d got %0d", exp_res.out_col, result.out_col);
                    err_cnt++;
                end
                if (result.frame_last !== exp_res.frame_last)
                begin
                    $error("frame_last exp %0d got %0d", exp_res.frame_last,
                           result.frame_last);
                    err_cnt++;
                end
            end
        end
        if (rst_n)
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        dir_row_t    dir_tab [12];
        item_t       it;
        int unsigned fed, img, ks, pad, side;
        dir_tab = '{
            '{'{OP_COEF,  6'd0,  16'sh7FFF, 16'sh0000}, 1'b0, '0},
            '{'{OP_PIXEL, 6'd0,  16'sh0000, 16'sh7FFF}, 1'b1,
              '{40'sh003FFF0001, 8'd0, 8'd0, 1'b1}},
            '{'{OP_PIXEL, 6'd63, 16'sh0000, 16'sh8000}, 1'b1,
              '{40'shFFC0008000, 8'd0, 8'd0, 1'b1}},
            '{'{OP_COEF,  6'd0,  16'sh8000, 16'sh0000}, 1'b0, '0},
            '{'{OP_PIXEL, 6'd0,  16'sh0000, 16'sh8000}, 1'b1,
              '{40'sh0040000000, 8'd0, 8'd0, 1'b1}},
            '{'{OP_PIXEL, 6'd0,  16'sh0000, 16'sh0000}, 1'b1,
              '{40'sh0, 8'd0, 8'd0, 1'b1}},
            '{'{OP_COEF,  6'd63, 16'sh1234, 16'sh0000}, 1'b0, '0},
            '{'{OP_COEF,  6'd49, 16'sh4321, 16'sh0000}, 1'b0, '0},
            '{'{OP_PIXEL, 6'd0,  16'sh0000, 16'sh0100}, 1'b1,
              '{40'shFFFF800000, 8'd0, 8'd0, 1'b1}},
            '{'{OP_COEF,  6'd0,  16'sh0100, 16'sh0000}, 1'b0, '0},
            '{'{OP_PIXEL, 6'd0,  16'sh0000, 16'sh0100}, 1'b1,
              '{40'sh0000010000, 8'd0, 8'd0, 1'b1}},
            '{'{OP_PIXEL, 6'd0,  16'shFFFF, 16'shFFFF}, 1'b1,
              '{40'shFFFFFFFF00, 8'd0, 8'd0, 1'b1}}
        };
        foreach (row_mem[a, b])
            row_mem[a][b] = 0;
        pos_row = 0;
        pos_col = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every coefficient gets a value before any window reads it
        for (int k = 0; k < COEF_DEPTH; k++)
        begin
            it            = '0;
            it.op         = OP_COEF;
            it.coef_index = 6'(k);
            it.coef_value = rand_sample();
            send_req(it, 1'b0, '0);
        end
        // one frame at the reset sizes
        for (int k = 0; k < 64; k++)
        begin
            it       = '0;
            it.op    = OP_PIXEL;
            it.pixel = rand_sample();
            send_req(it, 1'b0, '0);
        end
        drain();

        // directed table on a 1x1 image with a 1x1 kernel
        reg_write(REG_IMAGE_SIZE, 1);
        reg_write(REG_KERNEL_SIZE, 1);
        reg_write(REG_PAD_WIDTH, 0);
        foreach (dir_tab[k])
            send_req(dir_tab[k].it, dir_tab[k].typed, dir_tab[k].res);
        drain();

        // first epoch: sender idles often, receiver stalls most of the time
        send_idle_pct  = 35;
        recv_stall_pct = 82;
        run_frames(1, 7, 0, 40);     // kernel larger than padded image
        run_frames(0, 0, 0, 20);     // zero sizes act as one
        run_frames(3, 7, 2, 120);    // one window per frame, wide border
        run_frames(255, 3, 7, 300);  // oversized image and pad clamp

        // second epoch: roles swapped
        send_idle_pct  = 82;
        recv_stall_pct = 35;
        run_frames(128, 7, 4, 1000); // largest frame, first rows only
        fed = 0;
        while (fed < 300)
        begin
            if (fed >= 150)
            begin
                // third epoch: full rate both ways
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            img  = $urandom_range(1, 10);
            ks   = $urandom_range(0, 7);
            pad  = $urandom_range(0, 7);
            side = img + 2 * (pad > MAX_PAD ? MAX_PAD : pad);
            run_frames(img, ks, pad, side * side * $urandom_range(1, 2) + $urandom_range(3));
            fed += side * side;
        end

        if (err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
